[sv/cktm_pkg.sv]
// Package for the carrier keying timeout monitor.
// Holds widths, register indexes, command codes and the shared structs.
// No dependencies.
package cktm_pkg;

    // counter width of the tick counters
    localparam int COUNT_BITS = 16;
    // configuration register data width
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    // common width for comparing counters against register values
    localparam int WIDE_W     = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_TICKS  = 3'd0,
        REG_TIMEOUT_ENABLE = 3'd1,
        REG_PRESS_LIMIT    = 3'd2,
        REG_CHECK_DIVISOR  = 3'd3,
        REG_CHECK_ENABLE   = 3'd4
    } cfg_index_t;

    localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RST = 16'd1500;
    localparam logic [CFG_W-1:0] PRESS_LIMIT_RST   = 16'd30;
    localparam logic [CFG_W-1:0] CHECK_DIVISOR_RST = 16'd20;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_UNKEY   = 2'd2,
        CMD_TIMEOUT = 2'd3
    } radio_cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] timeout_ticks;
        logic             timeout_enable;
        logic [CFG_W-1:0] press_limit;
        logic [CFG_W-1:0] check_divisor;
        logic             check_enable;
    } cfg_t;

    typedef struct packed {
        radio_cmd_t radio_command;
        logic       shutdown_request;
        logic       check_strobe;
        logic       halted;
    } result_t;

endpackage

[sv/cktm_cfg_regs.sv]
// Configuration register file for the carrier keying timeout monitor.
// Plain write port, no read-back. Depends on cktm_pkg.
module cktm_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cktm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cktm_pkg::CFG_W-1:0]     cfg_wdata,
    output cktm_pkg::cfg_t                 cfg
);
    import cktm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_TIMEOUT_TICKS:  cfg_next.timeout_ticks  = cfg_wdata;
                REG_TIMEOUT_ENABLE: cfg_next.timeout_enable = cfg_wdata[0];
                REG_PRESS_LIMIT:    cfg_next.press_limit    = cfg_wdata;
                REG_CHECK_DIVISOR:  cfg_next.check_divisor  = cfg_wdata;
                REG_CHECK_ENABLE:   cfg_next.check_enable   = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks  <= TIMEOUT_TICKS_RST;
            cfg_reg.timeout_enable <= 1'b1;
            cfg_reg.press_limit    <= PRESS_LIMIT_RST;
            cfg_reg.check_divisor  <= CHECK_DIVISOR_RST;
            cfg_reg.check_enable   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/cktm_tick_core.sv]
// Per-tick state and update logic of the carrier keying timeout monitor.
// State advances on step; the result is combinational. Depends on cktm_pkg.
module cktm_tick_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  cktm_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic              carrier,
    input  logic              switch_lvl,
    output cktm_pkg::result_t result
);
    import cktm_pkg::*;

    localparam int PW = WIDE_W + 1;

    logic                  last_carrier_reg, last_carrier_next;
    logic [COUNT_BITS-1:0] countdown_reg, countdown_next;
    logic                  armed_reg, armed_next;
    logic [COUNT_BITS-1:0] held_reg, held_next;
    logic [COUNT_BITS-1:0] phase_reg, phase_next;
    logic                  stopped_reg, stopped_next;

    logic            pressed;
    logic [PW-1:0]   phase_inc;
    logic [PW-1:0]   div_w;
    radio_cmd_t      cmd;
    logic            sd;
    logic            strobe;

    assign pressed   = ~switch_lvl;
    assign phase_inc = PW'(phase_reg) + PW'(1);
    // zero divisor behaves as one
    assign div_w     = (cfg.check_divisor == '0) ? PW'(1) : PW'(cfg.check_divisor);

    always_comb begin
        last_carrier_next = last_carrier_reg;
        countdown_next    = countdown_reg;
        armed_next        = armed_reg;
        held_next         = held_reg;
        phase_next        = phase_reg;
        stopped_next      = stopped_reg;
        cmd               = CMD_NONE;
        sd                = 1'b0;
        strobe            = 1'b0;

        if (!stopped_reg) begin
            if (carrier != last_carrier_reg) begin
                last_carrier_next = carrier;
                if (carrier) begin
                    cmd            = CMD_KEY;
                    countdown_next = COUNT_BITS'(cfg.timeout_ticks);
                    armed_next     = 1'b1;
                end else begin
                    cmd = CMD_UNKEY;
                end
            end else if (cfg.timeout_enable && armed_reg) begin
                if (countdown_reg != '0) begin
                    if (carrier) countdown_next = countdown_reg - COUNT_BITS'(1);
                end else begin
                    // fires once even if carrier already dropped
                    cmd        = CMD_TIMEOUT;
                    armed_next = 1'b0;
                end
            end

            if (pressed) begin
                if (held_reg != CNT_MAX) held_next = held_reg + COUNT_BITS'(1);
                if (WIDE_W'(held_next) > WIDE_W'(cfg.press_limit)) begin
                    sd           = 1'b1;
                    stopped_next = 1'b1;
                end
            end else begin
                held_next = '0;
            end

            if (!stopped_next) begin
                strobe = (phase_reg == '0) && cfg.check_enable;
                if (phase_inc >= div_w) phase_next = '0;
                else                    phase_next = COUNT_BITS'(phase_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_carrier_reg <= 1'b0;
            countdown_reg    <= '0;
            armed_reg        <= 1'b0;
            held_reg         <= '0;
            phase_reg        <= '0;
            stopped_reg      <= 1'b0;
        end else if (step) begin
            last_carrier_reg <= last_carrier_next;
            countdown_reg    <= countdown_next;
            armed_reg        <= armed_next;
            held_reg         <= held_next;
            phase_reg        <= phase_next;
            stopped_reg      <= stopped_next;
        end
    end

    assign result.radio_command    = cmd;
    assign result.shutdown_request = sd;
    assign result.check_strobe     = strobe;
    assign result.halted           = stopped_reg | stopped_next;

endmodule

[sv/cos_keying_timeout_monitor.sv]
// Carrier keying timeout monitor, top level.
// Input register, per-tick core and result register. Depends on cktm_pkg,
// cktm_cfg_regs and cktm_tick_core.
//
// Each item on the s_ channel is one poll tick: carrier level and the
// active-low shutdown switch level. Each tick yields exactly one item on the
// m_ channel: radio command (key, unkey, timeout unkey), shutdown request,
// periodic check strobe and the halted flag.
// A tick accepted on s_ passes the input register, then the result register,
// before it is presented on m_. Throughput: one tick per cycle while m_ready is
// high; the tick logic is a single pass of counter updates between registers.
// When m_ready is low the result register holds, the input register still
// takes one more tick, and s_ready drops once both are full; nothing is lost.
// Registers are written through cfg_we/cfg_index/cfg_wdata; unknown indexes are
// ignored. Write only while no tick is in flight; the block does not enforce it.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults and clears carrier history, counters and halted state.
// After a shutdown request every later tick returns no command with halted set.
module cos_keying_timeout_monitor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cktm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cktm_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_carrier_level,
    input  logic                           s_switch_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_radio_command,
    output logic                           m_shutdown_request,
    output logic                           m_check_strobe,
    output logic                           m_halted
);
    import cktm_pkg::*;

    cfg_t    cfg;
    result_t core_result;

    logic    in_valid_reg, in_valid_next;
    logic    carrier_reg, switch_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    advance;
    logic    s_fire;

    cktm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cktm_tick_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (advance),
        .carrier    (carrier_reg),
        .switch_lvl (switch_reg),
        .result     (core_result)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign s_fire         = s_valid && s_ready;
    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            carrier_reg <= s_carrier_level;
            switch_reg  <= s_switch_level;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_radio_command    = out_reg.radio_command;
    assign m_shutdown_request = out_reg.shutdown_request;
    assign m_check_strobe     = out_reg.check_strobe;
    assign m_halted           = out_reg.halted;

endmodule
